// ===== rtl/core/nse_pkg.sv =====
// ----------------------------------------------------------------------------
// nse_pkg
// Shared types, codes, sizes and the activation table of the sparse network
// evaluator.
// ----------------------------------------------------------------------------
package nse_pkg;

  localparam int DEF_MAX_INPUTS      = 16;
  localparam int DEF_MAX_OUTPUTS     = 16;
  localparam int DEF_MAX_HIDDEN      = 64;
  localparam int DEF_MAX_CONNECTIONS = 256;

  // activation table covers |x| in [0,4) of Q8.24 sums
  localparam int SIGMOID_TABLE_SIZE = 256;
  localparam int TBL_W              = $clog2(SIGMOID_TABLE_SIZE);
  localparam int ACT_W              = 13;
  localparam logic [ACT_W-1:0] ACT_ONE = 13'd4096;

  localparam logic [63:0] Q31_ONE  = 64'd2147483648;
  // 4.9 * 2.0 * 2 * 2^32: exp(-19.6 x) rate in Q32
  localparam logic [63:0] RATE_Q32 = 64'd84181359002;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 5;

  typedef enum logic [CFG_AW-1:0] {
    CFG_INPUT_COUNT  = 1'd0,
    CFG_OUTPUT_COUNT = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_LOAD_CONN   = 3'd0,
    OP_SET_INPUT   = 3'd1,
    OP_PROPAGATE   = 3'd2,
    OP_CLEAR_VALUE = 3'd3,
    OP_CLEAR_NET   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CONN_FULL   = 3'd1,
    ST_HIDDEN_FULL = 3'd2,
    ST_BAD_TARGET  = 3'd3,
    ST_BAD_INDEX   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_CHK,
    S_HRD,
    S_HCMP,
    S_DECIDE,
    S_ALLOC_S,
    S_ALLOC_D,
    S_CONN_WR,
    S_P_CRD,
    S_P_NRD,
    S_P_MUL,
    S_P_ACC,
    S_P_WR,
    S_O_RD,
    S_O_EMIT,
    S_DONE
  } fsm_t;

  // control strobes from the sequencer to the MAC unit
  typedef struct packed {
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

  typedef logic [SIGMOID_TABLE_SIZE-1:0][ACT_W-1:0] act_tbl_t;

  // restoring long division for the table build
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], a[k]};
      if (r >= b) begin
        r    = r - b;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(4096 * (1-E)/(1+E)), E = exp(-19.6 i/(32*SIZE)) via Q31 Taylor + squaring
  function automatic act_tbl_t build_act_table();
    act_tbl_t    tbl;
    logic [63:0] tq32, u, term, e, num, den;
    for (int i = 0; i < SIGMOID_TABLE_SIZE; i++) begin
      tq32 = (64'(i) * RATE_Q32) >> TBL_W;
      u    = tq32 >> 11;
      term = Q31_ONE;
      e    = Q31_ONE;
      for (int n = 1; n <= 14; n++) begin
        term = udiv64((term * u) >> 31, 64'(n));
        if ((n & 1) == 1) e = e - term;
        else              e = e + term;
      end
      for (int k = 0; k < 5; k++) e = (e * e) >> 31;
      if (e > Q31_ONE) e = Q31_ONE;
      num = Q31_ONE - e;
      den = Q31_ONE + e;
      tbl[i] = ACT_W'(udiv64(num * 64'd8192 + den, den << 1));
    end
    return tbl;
  endfunction

  localparam act_tbl_t ACT_TABLE = build_act_table();

endpackage

// ===== rtl/core/nse_ram.sv =====
// ----------------------------------------------------------------------------
// nse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/nse_mac.sv =====
// ----------------------------------------------------------------------------
// nse_mac
// Shared multiply / saturating accumulate unit with tanh table activation.
// ----------------------------------------------------------------------------
module nse_mac
  import nse_pkg::*;
(
  input  logic               clk,
  input  mac_ctl_t           ctl,
  input  logic signed [15:0] value,
  input  logic signed [15:0] weight,
  input  logic signed [31:0] sum_in,
  output logic signed [31:0] acc,
  output logic signed [15:0] act
);

  logic signed [31:0] prod_r, hold_r, acc_r;
  logic signed [32:0] wide;
  logic signed [31:0] acc_nxt;
  logic        [32:0] mag;
  logic        [ACT_W-1:0] tval;

  always_comb begin
    wide = 33'(prod_r) + 33'(hold_r);
    if (wide > 33'sh0_7FFF_FFFF)       acc_nxt = 32'sh7FFF_FFFF;
    else if (wide < -33'sh0_8000_0000) acc_nxt = 32'sh8000_0000;
    else                               acc_nxt = wide[31:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= value * weight;
      hold_r <= sum_in;
    end
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // index = |sum| * SIZE >> 26
  always_comb begin
    mag = acc_r[31] ? (33'd0 - 33'(acc_r)) : 33'(acc_r);
    if (mag[32:26] != '0) tval = ACT_ONE;
    else                  tval = ACT_TABLE[mag[25:26-TBL_W]];
    act = acc_r[31] ? (16'sd0 - 16'(tval)) : 16'(tval);
  end

  assign acc = acc_r;

endmodule

// ===== rtl/core/sparse_neuroevolution_net_eval.sv =====
// ----------------------------------------------------------------------------
// sparse_neuroevolution_net_eval
// Evaluator for an evolved sparse network: connection store, hidden-id
// table, node value/sum memories and one shared MAC under a sequencer.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and each
// result appears on the out_ ports for exactly one cycle with out_valid high;
// it must be captured then, nothing holds it. Set input, clear and unknown
// operations go to S_DONE. A load runs S_LOAD_CHK, an S_HRD/S_HCMP pair per
// stored hidden id if an endpoint is a hidden node, S_DECIDE, S_ALLOC_S,
// S_ALLOC_D, S_CONN_WR. Propagate runs S_P_CRD..S_P_WR per connection via
// the shared MAC and single node-memory read ports, then S_O_RD, S_O_EMIT per
// output. Node values and sums start at zero after reset, no clearing pass.
// ----------------------------------------------------------------------------
module sparse_neuroevolution_net_eval
  import nse_pkg::*;
#(
  parameter int MAX_INPUTS      = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS     = DEF_MAX_OUTPUTS,
  parameter int MAX_HIDDEN      = DEF_MAX_HIDDEN,
  parameter int MAX_CONNECTIONS = DEF_MAX_CONNECTIONS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic               in_enabled,
  input  logic [15:0]        in_source_id,
  input  logic [15:0]        in_target_id,
  input  logic signed [15:0] in_weight,
  input  logic [3:0]         in_input_index,
  input  logic signed [15:0] in_input_value,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [3:0]         out_output_index,
  output logic signed [15:0] out_output_value,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_wdata
);

  localparam int NODE_SLOTS = MAX_INPUTS + MAX_OUTPUTS + MAX_HIDDEN;
  localparam int SLOT_W     = $clog2(NODE_SLOTS);
  localparam int CONN_AW    = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
  localparam int CNT_W      = $clog2(MAX_CONNECTIONS + 1);
  localparam int HID_AW     = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int HC_W       = $clog2(MAX_HIDDEN + 1);
  localparam int CONN_W     = 2 * SLOT_W + 16;

  fsm_t state_r, state_nxt;

  logic [CFG_DW-1:0] incnt_r, outcnt_r;
  logic [CNT_W-1:0]  conn_cnt_r, conn_cnt_nxt, ci_r, ci_nxt;
  logic [HC_W-1:0]   hid_cnt_r, hid_cnt_nxt, j_r, j_nxt;
  logic              en_r, en_nxt;
  logic [15:0]       src_r, src_nxt, dst_r, dst_nxt;
  logic signed [15:0] w_r, w_nxt, cw_r, cw_nxt;
  logic [2:0]        status_r, status_nxt;
  logic              s_found_r, s_found_nxt, d_found_r, d_found_nxt;
  logic [HID_AW-1:0] s_idx_r, s_idx_nxt, d_idx_r, d_idx_nxt;
  logic [SLOT_W-1:0] t_r, t_nxt;
  logic              vok_r, vok_nxt, sok_r, sok_nxt;
  logic [6:0]        o_r, o_nxt;
  logic [NODE_SLOTS-1:0] val_vld_r, val_vld_nxt, sum_vld_r, sum_vld_nxt;

  logic               out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [3:0]         out_idx_r, out_idx_nxt;
  logic signed [15:0] out_val_r, out_val_nxt;

  // effective counts, clamped to 1..MAX
  logic [6:0] ic7, oc7;
  logic [7:0] icoc;
  logic       src_h, dst_h;
  logic [1:0] need;

  // memory ports
  logic               v_we, s_we, h_we, c_we;
  logic [SLOT_W-1:0]  v_waddr, v_raddr, s_waddr, s_raddr;
  logic signed [15:0] v_wdata, v_rdata;
  logic signed [31:0] s_wdata, s_rdata;
  logic [HID_AW-1:0]  h_waddr, h_raddr;
  logic [15:0]        h_wdata, h_rdata;
  logic [CONN_AW-1:0] c_waddr, c_raddr;
  logic [CONN_W-1:0]  c_wdata, c_rdata;
  logic [SLOT_W-1:0]  ss, ts, c_src, c_dst;

  mac_ctl_t           mac_ctl;
  logic signed [15:0] mac_a;
  logic signed [31:0] mac_sum, mac_acc;
  logic signed [15:0] mac_act;

  logic accept;
  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    logic [6:0] ri, ro;
    ri = {2'b0, incnt_r};
    ro = {2'b0, outcnt_r};
    if (ri == 7'd0)                 ic7 = 7'd1;
    else if (ri > 7'(MAX_INPUTS))   ic7 = 7'(MAX_INPUTS);
    else                            ic7 = ri;
    if (ro == 7'd0)                 oc7 = 7'd1;
    else if (ro > 7'(MAX_OUTPUTS))  oc7 = 7'(MAX_OUTPUTS);
    else                            oc7 = ro;
    icoc  = {1'b0, ic7} + {1'b0, oc7};
    src_h = src_r >= {8'd0, icoc};
    dst_h = dst_r >= {8'd0, icoc};
    need  = {1'b0, src_h && !s_found_r}
          + {1'b0, dst_h && !d_found_r && !(src_h && (src_r == dst_r))};
  end

  // slot resolution for the connection being stored
  always_comb begin
    if (src_r < {9'd0, ic7})
      ss = SLOT_W'(src_r);
    else if (!src_h)
      ss = SLOT_W'(16'(MAX_INPUTS) + (src_r - {9'd0, ic7}));
    else
      ss = SLOT_W'(MAX_INPUTS + MAX_OUTPUTS) + SLOT_W'(s_idx_r);
    if (!dst_h)
      ts = SLOT_W'(16'(MAX_INPUTS) + (dst_r - {9'd0, ic7}));
    else
      ts = SLOT_W'(MAX_INPUTS + MAX_OUTPUTS) + SLOT_W'(d_idx_r);
  end

  assign c_src = c_rdata[CONN_W-1 -: SLOT_W];
  assign c_dst = c_rdata[16 +: SLOT_W];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_LOAD_CONN)
            state_nxt = S_LOAD_CHK;
          else if (in_operation == OP_PROPAGATE)
            state_nxt = (conn_cnt_r == '0) ? S_O_RD : S_P_CRD;
          else
            state_nxt = S_DONE;
        end
      end
      S_LOAD_CHK: begin
        if (!en_r || conn_cnt_r >= CNT_W'(MAX_CONNECTIONS) || dst_r < {9'd0, ic7})
          state_nxt = S_DONE;
        else if ((src_h || dst_h) && hid_cnt_r != '0)
          state_nxt = S_HRD;
        else
          state_nxt = S_DECIDE;
      end
      S_HRD:     state_nxt = S_HCMP;
      S_HCMP:    state_nxt = ((j_r + HC_W'(1)) < hid_cnt_r) ? S_HRD : S_DECIDE;
      S_DECIDE: begin
        if (int'(hid_cnt_r) + int'(need) > MAX_HIDDEN) state_nxt = S_DONE;
        else                                           state_nxt = S_ALLOC_S;
      end
      S_ALLOC_S: state_nxt = S_ALLOC_D;
      S_ALLOC_D: state_nxt = S_CONN_WR;
      S_CONN_WR: state_nxt = S_DONE;
      S_P_CRD:   state_nxt = S_P_NRD;
      S_P_NRD:   state_nxt = S_P_MUL;
      S_P_MUL:   state_nxt = S_P_ACC;
      S_P_ACC:   state_nxt = S_P_WR;
      S_P_WR:    state_nxt = ((ci_r + CNT_W'(1)) < conn_cnt_r) ? S_P_CRD : S_O_RD;
      S_O_RD:    state_nxt = S_O_EMIT;
      S_O_EMIT:  state_nxt = ((o_r + 7'd1) == oc7) ? S_IDLE : S_O_RD;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs, memory control and datapath registers
  always_comb begin
    conn_cnt_nxt = conn_cnt_r;
    hid_cnt_nxt  = hid_cnt_r;
    ci_nxt       = ci_r;
    j_nxt        = j_r;
    en_nxt       = en_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    w_nxt        = w_r;
    cw_nxt       = cw_r;
    status_nxt   = status_r;
    s_found_nxt  = s_found_r;
    d_found_nxt  = d_found_r;
    s_idx_nxt    = s_idx_r;
    d_idx_nxt    = d_idx_r;
    t_nxt        = t_r;
    vok_nxt      = vok_r;
    sok_nxt      = sok_r;
    o_nxt        = o_r;
    val_vld_nxt  = val_vld_r;
    sum_vld_nxt  = sum_vld_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_val_nxt    = out_val_r;
    out_last_nxt   = out_last_r;

    v_we    = 1'b0;
    v_waddr = t_r;
    v_wdata = mac_act;
    v_raddr = c_src;
    s_we    = 1'b0;
    s_waddr = t_r;
    s_wdata = mac_acc;
    s_raddr = c_dst;
    h_we    = 1'b0;
    h_waddr = HID_AW'(hid_cnt_r);
    h_wdata = src_r;
    h_raddr = HID_AW'(j_r);
    c_we    = 1'b0;
    c_waddr = CONN_AW'(conn_cnt_r);
    c_wdata = {ss, ts, w_r};
    c_raddr = CONN_AW'(ci_r);
    mac_ctl = '0;
    mac_a   = vok_r ? v_rdata : 16'sd0;
    mac_sum = sok_r ? s_rdata : 32'sd0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          en_nxt      = in_enabled;
          src_nxt     = in_source_id;
          dst_nxt     = in_target_id;
          w_nxt       = in_weight;
          status_nxt  = ST_OK;
          s_found_nxt = 1'b0;
          d_found_nxt = 1'b0;
          j_nxt       = '0;
          ci_nxt      = '0;
          o_nxt       = '0;
          unique case (in_operation)
            OP_SET_INPUT: begin
              if ({3'd0, in_input_index} >= ic7) begin
                status_nxt = ST_BAD_INDEX;
              end else begin
                v_we    = 1'b1;
                v_waddr = SLOT_W'(in_input_index);
                v_wdata = in_input_value;
                val_vld_nxt[SLOT_W'(in_input_index)] = 1'b1;
              end
            end
            OP_PROPAGATE:   sum_vld_nxt = '0;
            OP_CLEAR_VALUE: val_vld_nxt = '0;
            OP_CLEAR_NET: begin
              conn_cnt_nxt = '0;
              hid_cnt_nxt  = '0;
              val_vld_nxt  = '0;
              sum_vld_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_LOAD_CHK: begin
        if (!en_r)                                   status_nxt = ST_OK;
        else if (conn_cnt_r >= CNT_W'(MAX_CONNECTIONS)) status_nxt = ST_CONN_FULL;
        else if (dst_r < {9'd0, ic7})                status_nxt = ST_BAD_TARGET;
      end
      S_HRD: ;
      S_HCMP: begin
        if (src_h && h_rdata == src_r) begin
          s_found_nxt = 1'b1;
          s_idx_nxt   = HID_AW'(j_r);
        end
        if (dst_h && h_rdata == dst_r) begin
          d_found_nxt = 1'b1;
          d_idx_nxt   = HID_AW'(j_r);
        end
        j_nxt = j_r + HC_W'(1);
      end
      S_DECIDE: begin
        if (int'(hid_cnt_r) + int'(need) > MAX_HIDDEN) status_nxt = ST_HIDDEN_FULL;
      end
      S_ALLOC_S: begin
        if (src_h && !s_found_r) begin
          h_we        = 1'b1;
          s_found_nxt = 1'b1;
          s_idx_nxt   = HID_AW'(hid_cnt_r);
          hid_cnt_nxt = hid_cnt_r + HC_W'(1);
          // same new id on both ends shares the slot
          if (dst_r == src_r) begin
            d_found_nxt = 1'b1;
            d_idx_nxt   = HID_AW'(hid_cnt_r);
          end
        end
      end
      S_ALLOC_D: begin
        if (dst_h && !d_found_r) begin
          h_we        = 1'b1;
          h_wdata     = dst_r;
          d_found_nxt = 1'b1;
          d_idx_nxt   = HID_AW'(hid_cnt_r);
          hid_cnt_nxt = hid_cnt_r + HC_W'(1);
        end
      end
      S_CONN_WR: begin
        c_we         = 1'b1;
        conn_cnt_nxt = conn_cnt_r + CNT_W'(1);
      end
      S_P_CRD: ;
      S_P_NRD: begin
        cw_nxt  = c_rdata[15:0];
        t_nxt   = c_dst;
        vok_nxt = val_vld_r[c_src];
        sok_nxt = sum_vld_r[c_dst];
      end
      S_P_MUL: mac_ctl.mul_en = 1'b1;
      S_P_ACC: mac_ctl.acc_en = 1'b1;
      S_P_WR: begin
        v_we = 1'b1;
        s_we = 1'b1;
        val_vld_nxt[t_r] = 1'b1;
        sum_vld_nxt[t_r] = 1'b1;
        ci_nxt = ci_r + CNT_W'(1);
      end
      S_O_RD: begin
        v_raddr = SLOT_W'(MAX_INPUTS) + SLOT_W'(o_r);
        vok_nxt = val_vld_r[SLOT_W'(MAX_INPUTS) + SLOT_W'(o_r)];
      end
      S_O_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_idx_nxt    = o_r[3:0];
        out_val_nxt    = vok_r ? v_rdata : 16'sd0;
        out_last_nxt   = (o_r + 7'd1) == oc7;
        o_nxt          = o_r + 7'd1;
      end
      S_DONE: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_idx_nxt    = '0;
        out_val_nxt    = '0;
        out_last_nxt   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      incnt_r     <= CFG_DW'(1);
      outcnt_r    <= CFG_DW'(1);
      conn_cnt_r  <= '0;
      hid_cnt_r   <= '0;
      val_vld_r   <= '0;
      sum_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      conn_cnt_r  <= conn_cnt_nxt;
      hid_cnt_r   <= hid_cnt_nxt;
      val_vld_r   <= val_vld_nxt;
      sum_vld_r   <= sum_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_INPUT_COUNT:  incnt_r  <= cfg_wdata;
          CFG_OUTPUT_COUNT: outcnt_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ci_r         <= ci_nxt;
    j_r          <= j_nxt;
    en_r         <= en_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    w_r          <= w_nxt;
    cw_r         <= cw_nxt;
    status_r     <= status_nxt;
    s_found_r    <= s_found_nxt;
    d_found_r    <= d_found_nxt;
    s_idx_r      <= s_idx_nxt;
    d_idx_r      <= d_idx_nxt;
    t_r          <= t_nxt;
    vok_r        <= vok_nxt;
    sok_r        <= sok_nxt;
    o_r          <= o_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_val_r    <= out_val_nxt;
    out_last_r   <= out_last_nxt;
  end

  nse_ram #(.WIDTH(16), .DEPTH(NODE_SLOTS)) u_value_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  nse_ram #(.WIDTH(32), .DEPTH(NODE_SLOTS)) u_sum_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  nse_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN)) u_hidden_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  nse_ram #(.WIDTH(CONN_W), .DEPTH(MAX_CONNECTIONS)) u_conn_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  nse_mac u_mac (
    .clk(clk), .ctl(mac_ctl), .value(mac_a), .weight(cw_r),
    .sum_in(mac_sum), .acc(mac_acc), .act(mac_act)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_output_index = out_idx_r;
  assign out_output_value = out_val_r;
  assign out_last         = out_last_r;

endmodule
